// File: rtl/core/hkc_pkg.sv
// Shared constants, codes and the US-layout key decoder of the keyboard code assembler.
`default_nettype none
package hkc_pkg;

    localparam int LINE_MAX    = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam int LIDX_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CODE_D  = QUEUE_DEPTH * LINE_MAX;
    localparam int CODE_AW = (CODE_D > 1) ? $clog2(CODE_D) : 1;
    localparam int LCNT_W  = 7;
    localparam int QCNT_W  = 3;
    localparam int CHAR_W  = 7;
    localparam int KEY_W   = 8;
    localparam int NKEYS   = 6;
    localparam int KCNT_W  = 3;

    localparam logic [7:0] SHIFT_MASK  = 8'h22;
    localparam logic [7:0] KEY_ENTER   = 8'h28;
    localparam logic [7:0] KEY_KPENTER = 8'h58;
    localparam logic [7:0] KEY_BKSP    = 8'h2A;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    function automatic logic [CHAR_W-1:0] decode_key(input logic [7:0] key, input logic shift);
        logic [CHAR_W-1:0] base;
        base = 7'h61 + CHAR_W'(key - 8'h04);
        if (key >= 8'h04 && key <= 8'h1D)
        begin
            return shift ? (base - 7'd32) : base;
        end
        case (key)
            8'h1E: return shift ? 7'h21 : 7'h31;
            8'h1F: return shift ? 7'h40 : 7'h32;
            8'h20: return shift ? 7'h23 : 7'h33;
            8'h21: return shift ? 7'h24 : 7'h34;
            8'h22: return shift ? 7'h25 : 7'h35;
            8'h23: return shift ? 7'h5E : 7'h36;
            8'h24: return shift ? 7'h26 : 7'h37;
            8'h25: return shift ? 7'h2A : 7'h38;
            8'h26: return shift ? 7'h28 : 7'h39;
            8'h27: return shift ? 7'h29 : 7'h30;
            8'h2D: return shift ? 7'h5F : 7'h2D;
            8'h2E: return shift ? 7'h2B : 7'h3D;
            8'h2F: return shift ? 7'h7B : 7'h5B;
            8'h30: return shift ? 7'h7D : 7'h5D;
            8'h31: return shift ? 7'h7C : 7'h5C;
            8'h33: return shift ? 7'h3A : 7'h3B;
            8'h34: return shift ? 7'h22 : 7'h27;
            8'h36: return shift ? 7'h3C : 7'h2C;
            8'h37: return shift ? 7'h3E : 7'h2E;
            8'h38: return shift ? 7'h3F : 7'h2F;
            8'h2C: return 7'h20;
            default: return 7'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/hid_keyboard_code_assembler.sv
// Top level: HID boot-keyboard report decoder, line buffer and code queue.
// A report walks its keys, copying the line into the queue at each Enter on a non-empty line;
// a read sends the oldest code one character at a time; clear and unused ops give a status.
// Throughput: one item at a time; the next transfer is taken in the cycle after the last result
//   is loaded, and a stalled output register holds the block.
// Reset clears line length, queue head and count; RAM contents stay undefined.
`default_nettype none
module hid_keyboard_code_assembler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] operation,
    input  wire logic [3:0] report_length,
    input  wire logic [7:0] modifier,
    input  wire logic [7:0] key_a,
    input  wire logic [7:0] key_b,
    input  wire logic [7:0] key_c,
    input  wire logic [7:0] key_d,
    input  wire logic [7:0] key_e,
    input  wire logic [7:0] key_f,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      result_kind,
    output logic [6:0]      code_char,
    output logic            last_of_run,
    output logic [6:0]      line_length,
    output logic [2:0]      codes_waiting,
    output logic            dropped_oldest
);

    localparam int LM = hkc_pkg::LINE_MAX;
    localparam int QD = hkc_pkg::QUEUE_DEPTH;
    localparam int LW = hkc_pkg::LCNT_W;
    localparam int LI = hkc_pkg::LIDX_W;
    localparam int QI = hkc_pkg::QIDX_W;
    localparam int QC = hkc_pkg::QCNT_W;
    localparam int CA = hkc_pkg::CODE_AW;
    localparam int CW = hkc_pkg::CHAR_W;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_KEY      = 6'b000010,
        S_COPY     = 6'b000100,
        S_EMIT     = 6'b001000,
        S_RD_ISSUE = 6'b010000,
        S_RD_WAIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [hkc_pkg::KEY_W-1:0] keys_reg [hkc_pkg::NKEYS];
    logic [hkc_pkg::KEY_W-1:0] keys_next [hkc_pkg::NKEYS];
    logic [hkc_pkg::KCNT_W-1:0] keys_left_reg, keys_left_next;
    logic shift_on_reg, shift_on_next;
    logic dropped_reg, dropped_next;
    hkc_pkg::kind_t kind_reg, kind_next;
    logic [LW-1:0] line_count_reg, line_count_next;
    logic [QI-1:0] q_head_reg, q_head_next;
    logic [QC-1:0] q_count_reg, q_count_next;
    logic [LW-1:0] code_len_reg [QD];
    logic [LW-1:0] code_len_next [QD];
    logic [QI-1:0] slot_reg, slot_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] rd_n_reg, rd_n_next;
    logic pend_reg, pend_next;
    logic [LI-1:0] pend_idx_reg, pend_idx_next;

    logic out_valid_reg, out_valid_next;
    hkc_pkg::kind_t out_kind_reg, out_kind_next;
    logic [CW-1:0] out_char_reg, out_char_next;
    logic out_last_reg, out_last_next;
    logic [LW-1:0] out_line_reg, out_line_next;
    logic [QC-1:0] out_codes_reg, out_codes_next;
    logic out_drop_reg, out_drop_next;

    // RAM ports
    logic line_we, line_re;
    logic [LI-1:0] line_waddr, line_raddr;
    logic [CW-1:0] line_wdata, line_rdata;
    logic code_we, code_re;
    logic [CA-1:0] code_waddr, code_raddr;
    logic [CW-1:0] code_rdata;

    logic can_emit;
    logic [hkc_pkg::KEY_W-1:0] key;
    logic [CW-1:0] key_char;
    logic [QI:0] tail_sum;
    logic [QI-1:0] tail_slot;
    logic [QI-1:0] head_inc;
    logic [3:0] eff_len;

    hkc_ram #(.DEPTH(LM), .WIDTH(CW), .AW(LI)) u_line_ram (
        .clk     (clk),
        .wr_en   (line_we),
        .wr_addr (line_waddr),
        .wr_data (line_wdata),
        .rd_en   (line_re),
        .rd_addr (line_raddr),
        .rd_data (line_rdata)
    );

    // Copy writes take line RAM data in the cycle after the read.
    hkc_ram #(.DEPTH(hkc_pkg::CODE_D), .WIDTH(CW), .AW(CA)) u_code_ram (
        .clk     (clk),
        .wr_en   (code_we),
        .wr_addr (code_waddr),
        .wr_data (line_rdata),
        .rd_en   (code_re),
        .rd_addr (code_raddr),
        .rd_data (code_rdata)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_kind    = out_kind_reg;
    assign code_char      = out_char_reg;
    assign last_of_run    = out_last_reg;
    assign line_length    = out_line_reg;
    assign codes_waiting  = out_codes_reg;
    assign dropped_oldest = out_drop_reg;

    // The output register frees when empty or when its transfer completes.
    assign can_emit = !out_valid_reg || out_ready;
    assign key      = keys_reg[0];
    assign key_char = hkc_pkg::decode_key(key, shift_on_reg);
    assign head_inc = (32'(q_head_reg) == QD - 1) ? '0 : q_head_reg + 1'b1;
    assign eff_len  = (report_length > 4'd8) ? 4'd8 : report_length;

    always_comb
    begin
        state_next     = state_reg;
        keys_next      = keys_reg;
        keys_left_next = keys_left_reg;
        shift_on_next  = shift_on_reg;
        dropped_next   = dropped_reg;
        kind_next      = kind_reg;
        line_count_next = line_count_reg;
        q_head_next    = q_head_reg;
        q_count_next   = q_count_reg;
        code_len_next  = code_len_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        rd_n_next      = rd_n_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_line_next  = out_line_reg;
        out_codes_next = out_codes_reg;
        out_drop_next  = out_drop_reg;

        line_we    = 1'b0;
        line_waddr = line_count_reg[LI-1:0];
        line_wdata = key_char;
        line_re    = 1'b0;
        line_raddr = idx_reg[LI-1:0];
        code_we    = pend_reg;
        code_waddr = CA'(slot_reg) * CA'(LM) + CA'(pend_idx_reg);
        code_re    = 1'b0;
        code_raddr = CA'(slot_reg) * CA'(LM) + CA'(idx_reg[LI-1:0]);

        // Tail slot of the queue after any drop of the oldest code.
        if (32'(q_count_reg) >= QD)
        begin
            tail_sum = {1'b0, head_inc} + (QI+1)'(QD - 1);
        end
        else
        begin
            tail_sum = {1'b0, q_head_reg} + (QI+1)'(q_count_reg);
        end
        if (32'(tail_sum) >= QD)
        begin
            tail_slot = QI'(32'(tail_sum) - QD);
        end
        else
        begin
            tail_slot = tail_sum[QI-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    keys_next[0]   = key_a;
                    keys_next[1]   = key_b;
                    keys_next[2]   = key_c;
                    keys_next[3]   = key_d;
                    keys_next[4]   = key_e;
                    keys_next[5]   = key_f;
                    shift_on_next  = |(modifier & hkc_pkg::SHIFT_MASK);
                    dropped_next   = 1'b0;
                    kind_next      = hkc_pkg::KIND_STATUS;
                    keys_left_next = (eff_len >= 4'd3) ? 3'(eff_len - 4'd2) : '0;
                    case (operation)
                        hkc_pkg::OP_REPORT: state_next = S_KEY;
                        hkc_pkg::OP_READ:
                        begin
                            if (q_count_reg == '0 || code_len_reg[q_head_reg] == '0)
                            begin
                                kind_next = hkc_pkg::KIND_EMPTY;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RD_ISSUE;
                            end
                            if (q_count_reg != '0)
                            begin
                                slot_next    = q_head_reg;
                                rd_n_next    = code_len_reg[q_head_reg];
                                idx_next     = '0;
                                q_head_next  = head_inc;
                                q_count_next = q_count_reg - 1'b1;
                            end
                        end
                        hkc_pkg::OP_CLEAR:
                        begin
                            line_count_next = '0;
                            state_next = S_EMIT;
                        end
                        default: state_next = S_EMIT;
                    endcase
                end
            end
            S_KEY:
            begin
                if (keys_left_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    // Advance to the next key byte.
                    for (int k = 0; k < hkc_pkg::NKEYS - 1; k++)
                    begin
                        keys_next[k] = keys_reg[k+1];
                    end
                    keys_left_next = keys_left_reg - 1'b1;
                    if (key == hkc_pkg::KEY_ENTER || key == hkc_pkg::KEY_KPENTER)
                    begin
                        if (line_count_reg != '0)
                        begin
                            if (32'(q_count_reg) >= QD)
                            begin
                                q_head_next  = head_inc;
                                dropped_next = 1'b1;
                                q_count_next = QC'(QD);
                            end
                            else
                            begin
                                q_count_next = q_count_reg + 1'b1;
                            end
                            slot_next = tail_slot;
                            code_len_next[tail_slot] = line_count_reg;
                            idx_next = '0;
                            state_next = S_COPY;
                        end
                    end
                    else if (key == hkc_pkg::KEY_BKSP)
                    begin
                        if (line_count_reg != '0)
                        begin
                            line_count_next = line_count_reg - 1'b1;
                        end
                    end
                    else if (key_char != '0 && 32'(line_count_reg) < LM)
                    begin
                        line_we = 1'b1;
                        line_count_next = line_count_reg + 1'b1;
                    end
                end
            end
            S_COPY:
            begin
                if (idx_reg < line_count_reg)
                begin
                    line_re       = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[LI-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    line_count_next = '0;
                    state_next = S_KEY;
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_char_next  = '0;
                    out_last_next  = 1'b0;
                    out_line_next  = line_count_reg;
                    out_codes_next = q_count_reg;
                    out_drop_next  = dropped_reg;
                    state_next = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                code_re = 1'b1;
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = hkc_pkg::KIND_CHAR;
                    out_char_next  = code_rdata;
                    out_last_next  = (idx_reg + 1'b1 == rd_n_reg);
                    out_line_next  = line_count_reg;
                    out_codes_next = q_count_reg;
                    out_drop_next  = 1'b0;
                    if (idx_reg + 1'b1 == rd_n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_RD_ISSUE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            line_count_reg <= '0;
            q_head_reg     <= '0;
            q_count_reg    <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_count_reg <= line_count_next;
            q_head_reg     <= q_head_next;
            q_count_reg    <= q_count_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg       <= keys_next;
        keys_left_reg  <= keys_left_next;
        shift_on_reg   <= shift_on_next;
        dropped_reg    <= dropped_next;
        kind_reg       <= kind_next;
        code_len_reg   <= code_len_next;
        slot_reg       <= slot_next;
        idx_reg        <= idx_next;
        rd_n_reg       <= rd_n_next;
        pend_idx_reg   <= pend_idx_next;
        out_kind_reg   <= out_kind_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
        out_line_reg   <= out_line_next;
        out_codes_reg  <= out_codes_next;
        out_drop_reg   <= out_drop_next;
    end

endmodule
`default_nettype wire

// File: rtl/core/hkc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module hkc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: bench/tb_hid_keyboard_code_assembler.sv
// Self-checking bench: keyboard reports, code reads and line clears against a decoder model.
`default_nettype none
module tb_hid_keyboard_code_assembler;
    timeunit 1ns;
    timeprecision 1ps;
    import hkc_pkg::*;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] report_length;
        logic [7:0] modifier;
        logic [7:0] key_a;
        logic [7:0] key_b;
        logic [7:0] key_c;
        logic [7:0] key_d;
        logic [7:0] key_e;
        logic [7:0] key_f;
    } report_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] ch;
        logic       last;
        logic [6:0] llen;
        logic [2:0] qcnt;
        logic       drop;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] operation = '0;
    logic [3:0] report_length = '0;
    logic [7:0] modifier = '0;
    logic [7:0] key_a = '0, key_b = '0, key_c = '0, key_d = '0, key_e = '0, key_f = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] result_kind;
    logic [6:0] code_char;
    logic last_of_run;
    logic [6:0] line_length;
    logic [2:0] codes_waiting;
    logic dropped_oldest;

    hid_keyboard_code_assembler uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .report_length(report_length), .modifier(modifier),
        .key_a(key_a), .key_b(key_b), .key_c(key_c),
        .key_d(key_d), .key_e(key_e), .key_f(key_f),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .code_char(code_char), .last_of_run(last_of_run),
        .line_length(line_length), .codes_waiting(codes_waiting),
        .dropped_oldest(dropped_oldest)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: partial line and ring of finished codes.
    logic [6:0] mdl_line [LINE_MAX];
    int         mdl_count;
    logic [6:0] mdl_codes [QUEUE_DEPTH][LINE_MAX];
    int         mdl_lens [QUEUE_DEPTH];
    int         mdl_head;
    int         mdl_queued;

    report_t  pending_items [$];
    outcome_t expected_results [$];
    int  errors = 0;
    int  timer = 0;
    bit  all_sent = 1'b0;
    bit  quiet = 1'b0;      // no idling in the closing part
    bit  hold_long = 1'b0;  // receiver holds off for the pressure stretch

    function automatic logic [6:0] us_char(logic [7:0] key, bit shift);
        string shifted_row;
        logic [7:0] ch;
        shifted_row = "!@#$%^&*(";
        ch = 8'h00;
        if (key >= 8'h04 && key <= 8'h1D)
            ch = shift ? ("A" + key - 8'h04) : ("a" + key - 8'h04);
        else if (key >= 8'h1E && key <= 8'h26)
            ch = shift ? shifted_row[key - 8'h1E] : ("1" + key - 8'h1E);
        else
        begin
            case (key)
                8'h27: ch = shift ? ")" : "0";
                8'h2D: ch = shift ? "_" : "-";
                8'h2E: ch = shift ? "+" : "=";
                8'h2F: ch = shift ? "{" : "[";
                8'h30: ch = shift ? "}" : "]";
                8'h31: ch = shift ? "|" : "\\";
                8'h33: ch = shift ? ":" : ";";
                8'h34: ch = shift ? "\"" : "'";
                8'h36: ch = shift ? "<" : ",";
                8'h37: ch = shift ? ">" : ".";
                8'h38: ch = shift ? "?" : "/";
                8'h2C: ch = " ";
                default: ch = 8'h00;
            endcase
        end
        return 7'(ch);
    endfunction

    function automatic outcome_t make_outcome(kind_t k, logic [6:0] c, bit l, bit d);
        outcome_t o;
        o.kind = k;
        o.ch = c;
        o.last = l;
        o.llen = 7'(mdl_count);
        o.qcnt = 3'(mdl_queued);
        o.drop = d;
        return o;
    endfunction

    // Advance the decoder state by one item and queue the results it produces.
    task automatic predict_decode(report_t it);
        logic [7:0] keys [6];
        bit shift, dropped;
        logic [6:0] c;
        int slot, n;
        keys = '{it.key_a, it.key_b, it.key_c, it.key_d, it.key_e, it.key_f};
        shift = (it.modifier & SHIFT_MASK) != 0;
        dropped = 1'b0;
        case (op_t'(it.operation))
            OP_REPORT:
            begin
                if (it.report_length >= 3)
                begin
                    for (int i = 2; i < it.report_length && i < 8; i++)
                    begin
                        if (keys[i-2] == 8'h00)
                            continue;
                        if (keys[i-2] == KEY_ENTER || keys[i-2] == KEY_KPENTER)
                        begin
                            if (mdl_count > 0)
                            begin
                                if (mdl_queued >= QUEUE_DEPTH)
                                begin
                                    mdl_head = (mdl_head + 1) % QUEUE_DEPTH;
                                    mdl_queued = QUEUE_DEPTH - 1;
                                    dropped = 1'b1;
                                end
                                slot = (mdl_head + mdl_queued) % QUEUE_DEPTH;
                                for (int j = 0; j < mdl_count; j++)
                                    mdl_codes[slot][j] = mdl_line[j];
                                mdl_lens[slot] = mdl_count;
                                mdl_queued++;
                                mdl_count = 0;
                            end
                        end
                        else if (keys[i-2] == KEY_BKSP)
                        begin
                            if (mdl_count > 0)
                                mdl_count--;
                        end
                        else
                        begin
                            c = us_char(keys[i-2], shift);
                            if (c != 0 && mdl_count < LINE_MAX)
                            begin
                                mdl_line[mdl_count] = c;
                                mdl_count++;
                            end
                        end
                    end
                end
                expected_results.push_back(make_outcome(KIND_STATUS, 7'h00, 1'b0, dropped));
            end
            OP_READ:
            begin
                if (mdl_queued == 0)
                    expected_results.push_back(make_outcome(KIND_EMPTY, 7'h00, 1'b0, 1'b0));
                else
                begin
                    slot = mdl_head;
                    n = mdl_lens[slot];
                    mdl_head = (slot + 1) % QUEUE_DEPTH;
                    mdl_queued--;
                    for (int j = 0; j < n; j++)
                        expected_results.push_back(make_outcome(KIND_CHAR, mdl_codes[slot][j],
                                                                j + 1 == n, 1'b0));
                end
            end
            default:
            begin
                if (op_t'(it.operation) == OP_CLEAR)
                    mdl_count = 0;
                expected_results.push_back(make_outcome(KIND_STATUS, 7'h00, 1'b0, 1'b0));
            end
        endcase
    endtask

    function automatic report_t build_report(logic [1:0] op, logic [3:0] len, logic [7:0] md,
                                             logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                             logic [7:0] d, logic [7:0] e, logic [7:0] f);
        report_t it;
        it = '{op, len, md, a, b, c, d, e, f};
        return it;
    endfunction

    // Pick a key: mostly printable, sometimes Enter, Backspace, none or any code.
    function automatic logic [7:0] pick_key(int enter_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < enter_weight)
            return ($urandom_range(0, 1) != 0) ? KEY_ENTER : KEY_KPENTER;
        if (r < enter_weight + 6)
            return KEY_BKSP;
        if (r < enter_weight + 12)
            return 8'h00;
        if (r < enter_weight + 20)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h04, 8'h38));
    endfunction

    function automatic report_t random_report(int enter_weight);
        report_t it;
        it.operation = OP_REPORT;
        it.report_length = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        it.modifier = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
        it.key_a = pick_key(enter_weight);
        it.key_b = pick_key(enter_weight);
        it.key_c = pick_key(enter_weight);
        it.key_d = pick_key(enter_weight);
        it.key_e = pick_key(enter_weight);
        it.key_f = pick_key(enter_weight);
        return it;
    endfunction

    // Driver: present the next pending item, hold it until transfer, idle in bursts.
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_decode(build_report(operation, report_length, modifier,
                                            key_a, key_b, key_c, key_d, key_e, key_f));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0 && (quiet || $urandom_range(0, 5) != 0))
                begin
                    {operation, report_length, modifier, key_a, key_b, key_c, key_d, key_e,
                     key_f} <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (pending_items.size() > 0 && !quiet)
                        send_gap <= $urandom_range(1, 7);
                    else if (pending_items.size() == 0 && all_sent == 1'b0)
                        send_gap <= 0;
                end
            end
        end
    end

    // Monitor: compare each transfer with the oldest expectation; stall in bursts.
    int recv_gap = 0;
    always @(posedge clk)
    begin
        outcome_t seen, want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = '{result_kind, code_char, last_of_run, line_length, codes_waiting,
                         dropped_oldest};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", seen);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected kind %0d char %h last %b len %0d",
                                      " q %0d drop %b, got kind %0d char %h last %b len %0d",
                                      " q %0d drop %b"},
                                     want.kind, want.ch, want.last, want.llen, want.qcnt,
                                     want.drop, seen.kind, seen.ch, seen.last, seen.llen,
                                     seen.qcnt, seen.drop);
                    end
                end
            end
            if (hold_long)
                out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                recv_gap <= $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on total cycles.
    always @(posedge clk)
    begin
        timer <= timer + 1;
        if (timer > 2000000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        report_t it;
        int phase_items;
        mdl_count = 0;
        mdl_head = 0;
        mdl_queued = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads on an empty queue, short reports, full line, drops.
        pending_items.push_back(build_report(OP_READ, 4'd0, 8'h00, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_report(OP_REPORT, 4'd2, 8'hFF, 8'h04, 8'h05, 8'h06,
                                             8'h07, 8'h08, 8'h09));
        pending_items.push_back(build_report(OP_REPORT, 4'd8, 8'h00, KEY_ENTER, KEY_BKSP,
                                             8'h00, 8'hFF, 8'h32, 8'h35));
        pending_items.push_back(build_report(OP_REPORT, 4'd8, 8'h02, 8'h04, 8'h1D, 8'h1E,
                                             8'h26, 8'h27, 8'h2C));
        pending_items.push_back(build_report(OP_REPORT, 4'd15, 8'h20, 8'h2D, 8'h2E, 8'h2F,
                                             8'h30, 8'h31, 8'h33));
        pending_items.push_back(build_report(OP_REPORT, 4'd8, 8'h00, 8'h34, 8'h36, 8'h37,
                                             8'h38, 8'h1E, 8'h27));
        pending_items.push_back(build_report(OP_REPORT, 4'd5, 8'hDD, 8'h04, 8'h05, 8'h06,
                                             KEY_ENTER, 8'h07, 8'h08));
        pending_items.push_back(build_report(OP_REPORT, 4'd8, 8'h00, KEY_KPENTER, 0, 0, 0, 0,
                                             0));
        for (int i = 0; i < 12; i++)
            pending_items.push_back(build_report(OP_REPORT, 4'd8, 8'($urandom_range(0, 255)),
                                                 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15));
        pending_items.push_back(build_report(OP_REPORT, 4'd8, 8'h00, KEY_ENTER, 8'h04,
                                             KEY_ENTER, 8'h05, KEY_KPENTER, 8'h06));
        pending_items.push_back(build_report(OP_REPORT, 4'd8, 8'h00, 8'h07, KEY_BKSP, KEY_BKSP,
                                             KEY_BKSP, 8'h08, KEY_ENTER));
        pending_items.push_back(build_report(OP_NONE, 4'd8, 8'h00, 8'h04, 0, 0, 0, 0, 0));
        pending_items.push_back(build_report(OP_REPORT, 4'd3, 8'h00, 8'h09, 8'h04, 0, 0, 0, 0));
        pending_items.push_back(build_report(OP_CLEAR, 4'd0, 8'h00, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 5; i++)
            pending_items.push_back(build_report(OP_READ, 4'd0, 8'h00, 0, 0, 0, 0, 0, 0));

        // Pressure: hold the receiver off while long codes are typed.
        hold_long = 1'b1;
        for (int i = 0; i < 30; i++)
            pending_items.push_back(random_report(4));
        repeat (400) @(posedge clk);
        hold_long = 1'b0;

        // Random typing sessions with reads, clears and noise mixed in.
        phase_items = 0;
        while (phase_items < 310)
        begin
            if (phase_items == 280)
                quiet = 1'b1;
            case ($urandom_range(0, 19))
                0: it = build_report(OP_CLEAR, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                                     8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom), 8'($urandom));
                1: it = build_report(OP_NONE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                                     8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom), 8'($urandom));
                2, 3, 4, 5: it = build_report(OP_READ, 4'($urandom_range(0, 15)),
                                              8'($urandom_range(0, 255)), 8'($urandom),
                                              8'($urandom), 8'($urandom), 8'($urandom),
                                              8'($urandom), 8'($urandom));
                default: it = random_report(($urandom_range(0, 3) == 0) ? 25 : 6);
            endcase
            pending_items.push_back(it);
            phase_items++;
            while (pending_items.size() > 8)
                @(posedge clk);
        end
        while (pending_items.size() > 0 || in_valid)
            @(posedge clk);
        all_sent = 1'b1;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
rtl/core/hkc_pkg.sv
rtl/core/hkc_ram.sv
rtl/core/hid_keyboard_code_assembler.sv
bench/tb_hid_keyboard_code_assembler.sv
